### src/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### src/ufe_pkg.sv
package ufe_pkg;

    localparam int NODE_W          = 10;
    localparam int SIZE_OUT_W      = 11;
    localparam logic [SIZE_OUT_W-1:0] SIZE_OUT_MAX = 11'h7FF;
    localparam int NODE_COUNT_DFLT = 1024;

    // Operation codes carried on the mode field.
    localparam logic MODE_FIND  = 1'b0;
    localparam logic MODE_UNITE = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_step;   // write one clearing-pass entry, advance
        logic accept;     // capture an input word
        logic load;       // start walking the selected operand
        logic use_b;      // selected operand is the second node
        logic walk_step;  // follow one parent link
        logic walk_done;  // root found, rewind for compression
        logic comp_step;  // point current node at root, advance
        logic size_rd_a;  // read size of first root
        logic size_rd_b;  // read size of second root
        logic cap_sa;     // capture size of first root
        logic finish;     // decide merge, drive result
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_unite;
        logic op_ok;      // selected operand is a stored node
        logic hit;        // parent read back equals current node
        logic clr_last;   // clearing pass at last entry
    } t_sts;

endpackage

### src/ufe_ctrl.sv
module ufe_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    output logic          o_busy,
    output ufe_pkg::t_cmd o_cmd,
    input  ufe_pkg::t_sts i_sts
);
    import ufe_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_LOAD  = 3'd2;
    localparam logic [2:0] S_WALK  = 3'd3;
    localparam logic [2:0] S_COMP  = 3'd4;
    localparam logic [2:0] S_SZA   = 3'd5;
    localparam logic [2:0] S_SZB   = 3'd6;
    localparam logic [2:0] S_DEC   = 3'd7;

    logic [2:0] r_state, n_state;
    logic       r_sel, n_sel;
    logic       op_last;

    assign o_busy  = (r_state != S_IDLE);
    assign op_last = !(i_sts.is_unite && !r_sel);

    always_comb begin
        o_cmd       = '0;
        o_cmd.use_b = r_sel;
        n_state     = r_state;
        n_sel       = r_sel;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.accept = 1'b1;
                    n_sel        = 1'b0;
                    n_state      = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                if (i_sts.op_ok) begin
                    n_state = S_WALK;
                end else if (op_last) begin
                    n_state = S_SZA;
                end else begin
                    n_sel   = 1'b1;
                    n_state = S_LOAD;
                end
            end
            S_WALK: begin
                if (i_sts.hit) begin
                    o_cmd.walk_done = 1'b1;
                    n_state         = S_COMP;
                end else begin
                    o_cmd.walk_step = 1'b1;
                end
            end
            S_COMP: begin
                if (!i_sts.hit) begin
                    o_cmd.comp_step = 1'b1;
                end else if (op_last) begin
                    n_state = S_SZA;
                end else begin
                    n_sel   = 1'b1;
                    n_state = S_LOAD;
                end
            end
            S_SZA: begin
                o_cmd.size_rd_a = 1'b1;
                n_state         = S_SZB;
            end
            S_SZB: begin
                o_cmd.size_rd_b = 1'b1;
                o_cmd.cap_sa    = 1'b1;
                n_state         = S_DEC;
            end
            S_DEC: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_sel   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
        end
    end

endmodule

### src/ufe_datapath.sv
module ufe_datapath #(
    parameter int NODE_COUNT = ufe_pkg::NODE_COUNT_DFLT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ufe_pkg::t_cmd                 i_cmd,
    output ufe_pkg::t_sts                 o_sts,
    input  logic                          i_mode,
    input  logic [ufe_pkg::NODE_W-1:0]    i_first_node,
    input  logic [ufe_pkg::NODE_W-1:0]    i_second_node,
    output logic                          o_valid,
    output logic [ufe_pkg::NODE_W-1:0]    o_root_node,
    output logic                          o_merged,
    output logic [ufe_pkg::SIZE_OUT_W-1:0] o_set_size
);
    import ufe_pkg::*;

    localparam int ADDR_W = $clog2(NODE_COUNT);
    localparam int SIZE_W = $clog2(NODE_COUNT + 1);
    localparam int CMP_W  = (SIZE_W > SIZE_OUT_W) ? SIZE_W : SIZE_OUT_W;

    logic [NODE_W-1:0] p_mem [NODE_COUNT];
    logic [SIZE_W-1:0] s_mem [NODE_COUNT];

    logic              r_mode;
    logic [NODE_W-1:0] r_a, r_b, r_cur, r_start, r_ra, r_rb, r_prd;
    logic              r_a_ok, r_b_ok;
    logic [SIZE_W-1:0] r_sa, r_srd;
    logic [ADDR_W-1:0] r_clr_cnt;
    logic              r_valid, r_merged;
    logic [NODE_W-1:0] r_root_out;
    logic [SIZE_OUT_W-1:0] r_size_out;

    logic [NODE_W-1:0] op, root_sel, big, small_root, res_root;
    logic              op_ok, do_merge;
    logic [ADDR_W-1:0] p_raddr, p_waddr, s_raddr, s_waddr;
    logic [NODE_W-1:0] p_wdata;
    logic [SIZE_W-1:0] s_wdata, sum, res_size;
    logic              p_we, s_we;
    logic [SIZE_W:0]   sum_wide;
    logic [CMP_W-1:0]  res_cmp;

    assign op       = i_cmd.use_b ? r_b : r_a;
    assign op_ok    = i_cmd.use_b ? r_b_ok : r_a_ok;
    assign root_sel = i_cmd.use_b ? r_rb : r_ra;

    assign o_sts.is_unite = (r_mode == MODE_UNITE);
    assign o_sts.op_ok    = op_ok;
    assign o_sts.hit      = (r_prd == r_cur);
    assign o_sts.clr_last = (r_clr_cnt == ADDR_W'(NODE_COUNT - 1));

    // Merge decision; second root size is on the size read port in the decide cycle.
    assign do_merge   = (r_mode == MODE_UNITE) && r_a_ok && r_b_ok && (r_ra != r_rb);
    assign big        = (r_sa < r_srd) ? r_rb : r_ra;
    assign small_root = (r_sa < r_srd) ? r_ra : r_rb;
    assign sum_wide   = (SIZE_W+1)'(r_sa) + (SIZE_W+1)'(r_srd);
    assign sum        = SIZE_W'(sum_wide);
    assign res_root   = do_merge ? big : r_ra;
    assign res_size   = do_merge ? sum : (r_a_ok ? r_sa : SIZE_W'(1));
    assign res_cmp    = CMP_W'(res_size);

    always_comb begin
        priority if (i_cmd.load) begin
            p_raddr = ADDR_W'(op);
        end else if (i_cmd.walk_step || i_cmd.comp_step) begin
            p_raddr = ADDR_W'(r_prd);
        end else if (i_cmd.walk_done) begin
            p_raddr = ADDR_W'(r_start);
        end else begin
            p_raddr = ADDR_W'(r_cur);
        end
    end

    always_comb begin
        p_we    = 1'b0;
        p_waddr = r_clr_cnt;
        p_wdata = NODE_W'(r_clr_cnt);
        priority if (i_cmd.clr_step) begin
            p_we = 1'b1;
        end else if (i_cmd.comp_step) begin
            p_we    = 1'b1;
            p_waddr = ADDR_W'(r_cur);
            p_wdata = root_sel;
        end else if (i_cmd.finish && do_merge) begin
            p_we    = 1'b1;
            p_waddr = ADDR_W'(small_root);
            p_wdata = big;
        end else begin
            p_we = 1'b0;
        end
    end

    always_comb begin
        priority if (i_cmd.size_rd_a) begin
            s_raddr = ADDR_W'(r_ra);
        end else if (i_cmd.size_rd_b) begin
            s_raddr = ADDR_W'(r_rb);
        end else begin
            s_raddr = ADDR_W'(r_ra);
        end
    end

    always_comb begin
        s_we    = 1'b0;
        s_waddr = r_clr_cnt;
        s_wdata = SIZE_W'(1);
        priority if (i_cmd.clr_step) begin
            s_we = 1'b1;
        end else if (i_cmd.finish && do_merge) begin
            s_we    = 1'b1;
            s_waddr = ADDR_W'(big);
            s_wdata = sum;
        end else begin
            s_we = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (p_we) begin
            p_mem[p_waddr] <= p_wdata;
        end
        r_prd <= p_mem[p_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (s_we) begin
            s_mem[s_waddr] <= s_wdata;
        end
        r_srd <= s_mem[s_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mode <= i_mode;
            r_a    <= i_first_node;
            r_b    <= i_second_node;
            r_a_ok <= (32'(i_first_node) < 32'(NODE_COUNT));
            r_b_ok <= (32'(i_second_node) < 32'(NODE_COUNT));
        end
        if (i_cmd.load) begin
            r_cur   <= op;
            r_start <= op;
            if (i_cmd.use_b) begin
                r_rb <= op;
            end else begin
                r_ra <= op;
            end
        end
        if (i_cmd.walk_step || i_cmd.comp_step) begin
            r_cur <= r_prd;
        end
        if (i_cmd.walk_done) begin
            r_cur <= r_start;
            if (i_cmd.use_b) begin
                r_rb <= r_cur;
            end else begin
                r_ra <= r_cur;
            end
        end
        if (i_cmd.cap_sa) begin
            r_sa <= r_srd;
        end
        if (i_cmd.finish) begin
            r_root_out <= res_root;
            r_merged   <= do_merge;
            r_size_out <= (res_cmp > CMP_W'(SIZE_OUT_MAX)) ? SIZE_OUT_MAX
                                                            : SIZE_OUT_W'(res_size);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
            r_valid   <= 1'b0;
        end else begin
            r_valid <= i_cmd.finish;
            if (i_cmd.clr_step) begin
                r_clr_cnt <= r_clr_cnt + ADDR_W'(1);
            end
        end
    end

    assign o_valid     = r_valid;
    assign o_root_node = r_root_out;
    assign o_merged    = r_merged;
    assign o_set_size  = r_size_out;

endmodule

### src/union_find_engine_top.sv
// Union-find engine: union by size with full path compression.
// Command side: raise start with i_mode, i_first_node and i_second_node; the word is
// taken at a clock edge where start is high and busy is low. i_mode 0 finds the root
// of i_first_node, i_mode 1 unites the sets of both nodes.
// Result side: o_valid strobes for one cycle with o_root_node, o_merged and
// o_set_size. The receiver cannot stall; every result must be taken in its cycle.
// With d the hops from a node to its root: a node at or beyond NODE_COUNT skips walk
// and compression, and union by size bounds d by log2(NODE_COUNT), 10 at 1024
// nodes. The parent walk and the compression pass each follow one link per cycle
// through the registered read port of the parent memory; that port sets the rate.
// busy drops in the strobe cycle, so the next word may be taken there.
// Reset: synchronous, active low. After reset a clearing pass over all NODE_COUNT
// entries (1024 by default) writes every parent entry to its own index and every
// size entry to one; busy is high throughout.
module union_find_engine_top #(
    parameter int NODE_COUNT = ufe_pkg::NODE_COUNT_DFLT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           i_mode,
    input  logic [ufe_pkg::NODE_W-1:0]     i_first_node,
    input  logic [ufe_pkg::NODE_W-1:0]     i_second_node,
    output logic                           o_valid,
    output logic [ufe_pkg::NODE_W-1:0]     o_root_node,
    output logic                           o_merged,
    output logic [ufe_pkg::SIZE_OUT_W-1:0] o_set_size
);
    import ufe_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // Controller: sequences clearing pass, walk, compression and merge.
    ufe_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_cmd   (cmd),
        .i_sts   (sts)
    );

    // Datapath: parent and size memories, walk registers, result register.
    ufe_datapath #(
        .NODE_COUNT (NODE_COUNT)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_mode        (i_mode),
        .i_first_node  (i_first_node),
        .i_second_node (i_second_node),
        .o_valid       (o_valid),
        .o_root_node   (o_root_node),
        .o_merged      (o_merged),
        .o_set_size    (o_set_size)
    );

endmodule

### src/ufe_checker.sv
`include "assert_macros.svh"

module ufe_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic        o_merged,
    input logic [10:0] o_set_size
);

    // An accepted word keeps the engine busy in the next cycle.
    `ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    // A result appears only as the engine returns to idle.
    `ASSERT_IMPL(a_result_idle, i_clk, i_rst_n, o_valid, !busy)
    // Each word yields a single strobe.
    `ASSERT_NEXT(a_strobe_single, i_clk, i_rst_n, o_valid, !o_valid)
    // A merge joins two sets of at least one node each.
    `ASSERT_IMPL(a_merge_size, i_clk, i_rst_n, o_valid && o_merged, o_set_size > 11'd1)

endmodule

bind union_find_engine_top ufe_checker u_ufe_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .start      (start),
    .busy       (busy),
    .o_valid    (o_valid),
    .o_merged   (o_merged),
    .o_set_size (o_set_size)
);
